// ===== rtl/uvd_pkg.sv =====
// Shared types and constants for the UV dose exposure controller.
`default_nettype none

package uvd_pkg;

  // Defaults for the top-level parameters.
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int DOSE_BITS_DEF   = 32;

  // Controller modes as reported on the result channel.
  typedef enum logic [1:0] {
    MODE_SETUP  = 2'd0,
    MODE_EXPOSE = 2'd1,
    MODE_DONE   = 2'd2
  } mode_t;

  // Target dose handling.
  localparam logic [15:0] TARGET_RESET = 16'd1100;
  localparam logic [15:0] TARGET_MAX   = 16'hFFFF;
  localparam logic [15:0] STEP_SHORT   = 16'd5;
  localparam logic [15:0] STEP_LONG    = 16'd50;
  localparam logic [3:0]  HOLD_MAX     = 4'd11;
  localparam logic [3:0]  HOLD_LONG    = 4'd10;

  // Cancel counter, signed: -1 locks out a restart until enter is released.
  localparam logic signed [3:0] CANCEL_CLEAR = 4'sd0;
  localparam logic signed [3:0] CANCEL_LIMIT = 4'sd6;
  localparam logic signed [3:0] CANCEL_MAX   = 4'sd7;
  localparam logic signed [3:0] CANCEL_LOCK  = -4'sd1;

  // Pause contributions in milliseconds.
  localparam logic [9:0] PAUSE_BUTTON    = 10'd100;
  localparam logic [9:0] PAUSE_EXPOSE    = 10'd500;
  localparam logic [9:0] PAUSE_BLINK_ON  = 10'd500;
  localparam logic [9:0] PAUSE_BLINK_OFF = 10'd250;
  localparam logic [9:0] PAUSE_DISMISS   = 10'd50;

  // UV scaling: dose gain per tick and shown index, both in 1/1024 units.
  localparam logic [4:0]  DOSE_GAIN  = 5'd25;
  localparam logic [22:0] UV_SCALE   = 23'd50;
  localparam logic [22:0] UV_OFFSET  = 23'd1024;
  localparam logic [22:0] UV_SHOWN_MAX = 23'd65535;

  // Battery percent: (s - 613) * 100 / 245 by a reciprocal multiply.
  // 1712000 = 100 * ceil(2^22 / 245); exact for every span offset below 245.
  localparam logic [16:0] BAT_LOW   = 17'd613;
  localparam logic [16:0] BAT_HIGH  = 17'd858;
  localparam logic [28:0] BAT_MULT  = 29'd1712000;
  localparam int          BAT_SHIFT = 22;
  localparam logic [6:0]  PCT_FULL  = 7'd100;

  // Controller state apart from the dose accumulator, whose width is a parameter.
  typedef struct packed {
    mode_t             mode;
    logic [15:0]       target;
    logic [3:0]        up_cnt;
    logic [3:0]        down_cnt;
    logic signed [3:0] cancel;
    logic              blink;
  } state_t;

  // One result item.
  typedef struct packed {
    logic [9:0]  pause_ms;
    logic [6:0]  battery_percent;
    logic        beeper_on;
    logic        done_shown;
    logic [15:0] uv_shown;
    logic [31:0] dose_so_far;
    logic [15:0] target_dose;
    logic [1:0]  mode;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/uvd_step.sv =====
// Single-pass step logic: next controller state and the result of one tick.
`default_nettype none

module uvd_step import uvd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DOSE_BITS   = DOSE_BITS_DEF
) (
  input  var state_t                 st,
  input  wire  [DOSE_BITS-1:0]       dose,
  input  wire                        up,
  input  wire                        down,
  input  wire                        enter,
  input  wire  [SAMPLE_BITS-1:0]     uv,
  input  wire  [SAMPLE_BITS-1:0]     bat,
  output state_t                     st_nxt,
  output logic [DOSE_BITS-1:0]       dose_nxt,
  output result_t                    res
);

  localparam logic [DOSE_BITS-1:0] DoseMax = '1;

  logic [16:0]          tgt_up;
  logic [15:0]          step;
  logic [DOSE_BITS:0]   dose_sum;
  logic [DOSE_BITS-1:0] dose_add;
  logic [DOSE_BITS-1:0] tgt_scaled;
  logic [9:0]           pause;
  logic                 shown;
  logic                 beep;

  always_comb begin
    st_nxt     = st;
    dose_nxt   = dose;
    pause      = '0;
    shown      = 1'b0;
    beep       = 1'b0;
    tgt_up     = '0;
    step       = STEP_SHORT;
    dose_add   = DOSE_BITS'(uv) * DOSE_BITS'(DOSE_GAIN);
    dose_sum   = {1'b0, dose} + {1'b0, dose_add};
    tgt_scaled = '0;

    case (st.mode)
      MODE_SETUP: begin
        // Up is applied before down, each with its own hold acceleration.
        if (up) begin
          st_nxt.up_cnt = (st.up_cnt < HOLD_MAX) ? st.up_cnt + 4'd1 : HOLD_MAX;
          step = (st_nxt.up_cnt > HOLD_LONG) ? STEP_LONG : STEP_SHORT;
          tgt_up = {1'b0, st.target} + {1'b0, step};
          st_nxt.target = tgt_up[16] ? TARGET_MAX : tgt_up[15:0];
          pause = pause + PAUSE_BUTTON;
        end else begin
          st_nxt.up_cnt = '0;
        end
        if (down) begin
          st_nxt.down_cnt = (st.down_cnt < HOLD_MAX) ? st.down_cnt + 4'd1 : HOLD_MAX;
          step = (st_nxt.down_cnt > HOLD_LONG) ? STEP_LONG : STEP_SHORT;
          st_nxt.target = (st_nxt.target < step) ? '0 : st_nxt.target - step;
          pause = pause + PAUSE_BUTTON;
        end else begin
          st_nxt.down_cnt = '0;
        end
        if (enter && (st.cancel >= CANCEL_CLEAR)) begin
          dose_nxt      = '0;
          st_nxt.cancel = CANCEL_CLEAR;
          st_nxt.mode   = MODE_EXPOSE;
          pause = pause + PAUSE_BUTTON;
        end
        if (!enter) begin
          st_nxt.cancel = CANCEL_CLEAR;
        end
      end
      MODE_EXPOSE: begin
        dose_nxt = dose_sum[DOSE_BITS] ? DoseMax : dose_sum[DOSE_BITS-1:0];
        if (enter) begin
          if (st.cancel < CANCEL_MAX) begin
            st_nxt.cancel = st.cancel + 4'sd1;
          end
        end else begin
          st_nxt.cancel = CANCEL_CLEAR;
        end
        if (st_nxt.cancel > CANCEL_LIMIT) begin
          st_nxt.cancel = CANCEL_LOCK;
          st_nxt.mode   = MODE_SETUP;
        end
        // Reaching the target overrides a cancel in the same tick.
        tgt_scaled = DOSE_BITS'({st.target, 10'b0});
        if (dose_nxt >= tgt_scaled) begin
          st_nxt.blink = 1'b0;
          st_nxt.mode  = MODE_DONE;
        end
        pause = PAUSE_EXPOSE;
      end
      MODE_DONE: begin
        st_nxt.blink = ~st.blink;
        if (st_nxt.blink) begin
          shown = 1'b1;
          beep  = 1'b1;
          pause = PAUSE_BLINK_ON;
        end else begin
          pause = PAUSE_BLINK_OFF;
        end
        if (enter) begin
          st_nxt.mode   = MODE_SETUP;
          st_nxt.cancel = CANCEL_LOCK;
          beep  = 1'b0;
          pause = pause + PAUSE_DISMISS;
        end
      end
      default: begin
        st_nxt.mode = MODE_SETUP;
      end
    endcase
  end

  // Shown UV index: sample*50 - 1024, floored at zero and held to 16 bits.
  logic [22:0] uv50;
  logic [22:0] uv_off;

  assign uv50   = 23'(uv) * UV_SCALE;
  assign uv_off = (uv50 > UV_OFFSET) ? uv50 - UV_OFFSET : '0;

  // Battery percent over the 613..858 window.
  logic [16:0] bat_w;
  logic [7:0]  bat_span;
  logic [28:0] bat_prod;
  logic [6:0]  pct;

  assign bat_w    = 17'(bat);
  assign bat_span = 8'(bat_w - BAT_LOW);
  assign bat_prod = 29'(bat_span) * BAT_MULT;

  always_comb begin
    if (bat_w < BAT_LOW) begin
      pct = '0;
    end else if (bat_w >= BAT_HIGH) begin
      pct = PCT_FULL;
    end else begin
      pct = bat_prod[BAT_SHIFT +: 7];
    end
  end

  always_comb begin
    res.mode            = st_nxt.mode;
    res.target_dose     = st_nxt.target;
    res.dose_so_far     = 32'(dose_nxt);
    res.uv_shown        = (uv_off > UV_SHOWN_MAX) ? 16'hFFFF : uv_off[15:0];
    res.done_shown      = shown;
    res.beeper_on       = beep;
    res.battery_percent = pct;
    res.pause_ms        = pause;
  end

endmodule

`default_nettype wire

// ===== rtl/uv_dose_exposure_controller.sv =====
// Top level of the UV dose exposure controller: input register, step logic, result register.
`default_nettype none

// One input item is one poll tick of the buttons, the UV sensor and the battery.
// The block holds a setup / exposing / done controller: in setup the up and down
// buttons trim the target dose (5 per tick, 50 per tick once held past ten ticks),
// enter starts an exposure that adds sample*25 per tick in 1/1024 UV-second units
// until the target is met or enter is held for more than six ticks, and done mode
// blinks and beeps until enter is pressed. Every item gives exactly one result item
// with the new mode, target, accumulated dose, shown UV index, blink and beeper
// flags, battery percent and the pause the firmware loop should wait. The block
// accepts one item every clock cycle while the result channel is not stalled; an item
// is held in the input register, passes once through the step logic between the two
// registers, and its result is held in the result register, which offers it on the
// result channel. A stalled result channel holds the result register and, once the
// input register is also full, drops in_tready. No clearing pass follows reset; the
// block is ready at once.
module uv_dose_exposure_controller import uvd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DOSE_BITS   = DOSE_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // up_pressed, down_pressed, enter_pressed, uv_sample, battery_sample, zero pad
  input  wire  [((3+2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // mode, target_dose, dose_so_far, uv_shown, done_shown, beeper_on,
  // battery_percent, pause_ms, zero pad
  output logic [87:0]                     out_tdata
);

  localparam int InFieldBits = 3 + 2 * SAMPLE_BITS;

  // Controller state.
  state_t               st_r;
  logic [DOSE_BITS-1:0] dose_r;

  // Input register.
  logic                   s1_valid_r;
  logic                   s1_up_r;
  logic                   s1_down_r;
  logic                   s1_enter_r;
  logic [SAMPLE_BITS-1:0] s1_uv_r;
  logic [SAMPLE_BITS-1:0] s1_bat_r;

  // Result register.
  logic    out_valid_r;
  result_t out_data_r;

  state_t               st_nxt;
  logic [DOSE_BITS-1:0] dose_nxt;
  result_t              res_nxt;
  logic                 s1_fire;
  logic                 out_free;
  logic                 in_fire;

  // The result register can take a new result when empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  uvd_step #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DOSE_BITS   (DOSE_BITS)
  ) u_step (
    .st       (st_r),
    .dose     (dose_r),
    .up       (s1_up_r),
    .down     (s1_down_r),
    .enter    (s1_enter_r),
    .uv       (s1_uv_r),
    .bat      (s1_bat_r),
    .st_nxt   (st_nxt),
    .dose_nxt (dose_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode     <= MODE_SETUP;
      st_r.target   <= TARGET_RESET;
      st_r.up_cnt   <= '0;
      st_r.down_cnt <= '0;
      st_r.cancel   <= CANCEL_CLEAR;
      st_r.blink    <= 1'b0;
      dose_r        <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      // The state only moves when an item's result is committed.
      if (s1_fire) begin
        st_r        <= st_nxt;
        dose_r      <= dose_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_up_r    <= in_tdata[0];
      s1_down_r  <= in_tdata[1];
      s1_enter_r <= in_tdata[2];
      s1_uv_r    <= in_tdata[3 +: SAMPLE_BITS];
      s1_bat_r   <= in_tdata[3 + SAMPLE_BITS +: SAMPLE_BITS];
    end
    if (s1_fire) begin
      out_data_r <= res_nxt;
    end
  end

  // The pad bits above the fields of in_tdata are ignored.
  logic in_pad_unused;
  assign in_pad_unused = ^in_tdata[$bits(in_tdata)-1:InFieldBits];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};

  // The cancel counter only ever holds -1 through 6.
  a_cancel_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cancel >= CANCEL_LOCK)
    else $error("cancel counter below lockout value");

  // Hold counters saturate at their ceiling.
  a_hold_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.up_cnt <= HOLD_MAX) && (st_r.down_cnt <= HOLD_MAX))
    else $error("hold counter past saturation");

  // Finishing an exposure means the dose has reached the target.
  a_done_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && st_r.mode == MODE_EXPOSE && st_nxt.mode == MODE_DONE)
    |=> (dose_r >= DOSE_BITS'({st_r.target, 10'b0})))
    else $error("done entered below target dose");

  // Done mode never touches the dose or the target.
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && st_r.mode == MODE_DONE) |=> ($stable(dose_r) && $stable(st_r.target)))
    else $error("dose or target changed in done mode");

endmodule

`default_nettype wire
